>>> design/peer_liveness_rank_table_unit_macros.svh
`ifndef PEER_LIVENESS_RANK_TABLE_UNIT_MACROS_SVH
`define PEER_LIVENESS_RANK_TABLE_UNIT_MACROS_SVH

// Both macros expect signals named clk and arst_n in the enclosing module.

`define PLRT_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

`define PLRT_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

>>> design/plrt_pkg.sv
`default_nettype none

package plrt_pkg;

	localparam int CLK_W = 48;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALIVE_WINDOW = 1'd1;

	localparam logic [7:0] OWN_INDEX_RESET = 8'd0;
	localparam logic [15:0] ALIVE_WINDOW_RESET = 16'd2000;
	localparam logic [7:0] LAST_RANK_UNSET = 8'hFF;
	localparam logic [7:0] LAST_LIVE_RESET = 8'd1;

	typedef struct packed {
		logic [7:0] node_index;
		logic [CLK_W-1:0] node_clock;
		logic [CLK_W-1:0] now_time;
	} in_t;

	typedef struct packed {
		logic [7:0] rank;
		logic [7:0] live_count;
		logic changed;
	} out_t;

	typedef struct packed {
		logic [CLK_W-1:0] peer_clock;
		logic [CLK_W-1:0] heard_time;
	} entry_t;

endpackage

`default_nettype wire

>>> design/plrt_ram.sv
`default_nettype none

module plrt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 255
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> design/peer_liveness_rank_table_unit.sv
// Peer liveness and rank table. Each accepted item is one heard report; if its node index is
// below TABLE_ENTRIES it is written into the peer table, and then the whole table is walked
// one entry per cycle through the single read port of the table RAM, dropping peers not heard
// within the alive window and counting live peers and, apart from the own index, peers whose
// clock is ahead. in_ready stays low from acceptance until the result is loaded into the output
// register; a result that is not taken holds the next result back. Occupancy is kept in one
// flip-flop per entry, so the table is empty right after reset with no clearing pass.
`default_nettype none

`include "peer_liveness_rank_table_unit_macros.svh"

module peer_liveness_rank_table_unit
	import plrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 255
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output out_t out_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [7:0] own_index_q;
	logic [15:0] alive_window_q;
	logic [TABLE_ENTRIES-1:0] occ_q;
	logic [CLK_W-1:0] now_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic eval_s1;
	logic [IDX_W-1:0] eval_idx_s1;
	logic [7:0] live_q;
	logic [7:0] rank_q;
	logic [7:0] last_live_q;
	logic [7:0] last_rank_q;
	logic out_valid_q;
	out_t out_q;

	logic accept;
	logic in_range;
	logic ram_we;
	entry_t ram_wdata;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t ent;
	logic [CLK_W:0] expire_time;
	logic alive;
	logic ahead;
	logic own_hit;
	logic issue;
	logic last_eval;

	assign in_ready = (state_q == ST_IDLE) && arst_n;
	assign accept = in_valid && in_ready;
	assign in_range = {1'b0, in_data.node_index} < 9'(TABLE_ENTRIES);
	assign ram_we = accept && in_range;
	assign ram_wdata = '{peer_clock: in_data.node_clock, heard_time: in_data.now_time};

	plrt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(in_data.node_index[IDX_W-1:0]),
		.wdata(ram_wdata),
		.raddr(rd_cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		ent = entry_t'(ram_rdata);
		expire_time = {1'b0, ent.heard_time} + (CLK_W + 1)'(alive_window_q);
		alive = {1'b0, now_q} < expire_time;
		ahead = ent.peer_clock > ent.heard_time;
		own_hit = (8'(eval_idx_s1) == own_index_q);
		issue = (state_q == ST_WALK) && (rd_cnt_q < CNT_W'(TABLE_ENTRIES));
		last_eval = eval_s1 && (eval_idx_s1 == IDX_W'(TABLE_ENTRIES - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_index_q <= OWN_INDEX_RESET;
			alive_window_q <= ALIVE_WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_INDEX: own_index_q <= cfg_data[7:0];
				REG_ALIVE_WINDOW: alive_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q <= '0;
			rd_cnt_q <= '0;
			eval_s1 <= 1'b0;
			live_q <= '0;
			rank_q <= '0;
			last_live_q <= LAST_LIVE_RESET;
			last_rank_q <= LAST_RANK_UNSET;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			eval_s1 <= issue;
			if (ram_we) begin
				occ_q[in_data.node_index[IDX_W-1:0]] <= (in_data.node_clock != '0);
			end
			if (eval_s1 && occ_q[eval_idx_s1]) begin
				if (alive) begin
					live_q <= live_q + 8'd1;
					if (!own_hit && ahead) begin
						rank_q <= rank_q + 8'd1;
					end
				end else begin
					occ_q[eval_idx_s1] <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WALK;
						rd_cnt_q <= '0;
						live_q <= '0;
						rank_q <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					if (last_eval) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						last_rank_q <= rank_q;
						last_live_q <= live_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_data.now_time;
		end
		eval_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q.rank <= rank_q;
			out_q.live_count <= live_q;
			out_q.changed <= (rank_q != last_rank_q) || (live_q != last_live_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`PLRT_ASSERT_NEXT(a_accept_starts_walk, accept,
		state_q == ST_WALK && rd_cnt_q == '0, "Accepted item did not start a walk at entry zero.")
	`PLRT_ASSERT_SAME(a_eval_in_walk, eval_s1, state_q == ST_WALK,
		"Table entry evaluated outside the walk.")
	`PLRT_ASSERT_SAME(a_rank_within_live, out_valid_q, out_q.rank <= out_q.live_count,
		"Rank exceeds the live count.")
	`PLRT_ASSERT_NEXT(a_result_tracks_last, state_q == ST_DONE && (!out_valid_q || out_ready),
		out_valid_q && last_rank_q == out_q.rank && last_live_q == out_q.live_count,
		"Result and remembered counts disagree.")

endmodule

`default_nettype wire
